// ===== sv/lce_pkg.sv =====
package lce_pkg;

  localparam int unsigned CODE_SPACE_DEF = 2048;
  localparam int unsigned MAX_CODE_W     = 12;
  localparam int unsigned SUM_W          = 14;
  localparam int unsigned MCS_W          = 4;
  localparam int unsigned PIX_W          = 8;

  typedef struct packed {
    logic [MAX_CODE_W-1:0] code;
    logic [3:0]            width;
    logic                  fin;
  } cmd_t;

  // Clamp the register to the supported range of two to eight.
  function automatic logic [3:0] eff_mcs(input logic [MCS_W-1:0] m);
    logic [3:0] r;
    r = m;
    if (m < 4'd2) r = 4'd2;
    if (m > 4'd8) r = 4'd8;
    return r;
  endfunction

endpackage

// ===== sv/lzw_code_stream_encoder.sv =====
// Channel   | Handshake         | Beat
// pixels    | push / full       | pixel_index_i, last_pixel_i
// codes     | pop / empty       | code_byte_o, last_byte_o
// config    | cfg_we_i          | cfg_wdata_i (min code size)
//
// The dictionary RAM is scanned one entry a cycle through its single read port; a hit
// ends the scan early. The byte packer runs from a four-deep command queue, gives one
// byte a cycle while pop is held and takes a new command only when no whole byte is left.
// Reset is asynchronous; the dictionary needs no clearing pass. Output stalls back up
// the queue, then hold full high.
module lzw_code_stream_encoder
  import lce_pkg::*;
#(
  parameter int unsigned CodeSpace = CODE_SPACE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [MCS_W-1:0] cfg_wdata_i,
  input  logic             push,
  output logic             full,
  input  logic [PIX_W-1:0] pixel_index_i,
  input  logic             last_pixel_i,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       code_byte_o,
  output logic             last_byte_o
);

  logic q_push, q_full, q_vld, q_pop;
  cmd_t q_in, q_out;

  lce_front #(
    .CodeSpace (CodeSpace)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .pixel_index_i (pixel_index_i),
    .last_pixel_i  (last_pixel_i),
    .q_push_o      (q_push),
    .q_cmd_o       (q_in),
    .q_full_i      (q_full)
  );

  lce_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .vld_o  (q_vld),
    .cmd_o  (q_out)
  );

  lce_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_vld_i   (q_vld),
    .cmd_i       (q_out),
    .cmd_pop_o   (q_pop),
    .empty       (empty),
    .pop         (pop),
    .code_byte_o (code_byte_o),
    .last_byte_o (last_byte_o)
  );

`ifndef SYNTHESIS
  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_vld)
    else $error("packer took a command from an empty queue");
`endif

endmodule

// ===== sv/lce_ram.sv =====
module lce_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/lce_front.sv =====
module lce_front
  import lce_pkg::*;
#(
  parameter int unsigned CodeSpace = CODE_SPACE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [MCS_W-1:0] cfg_wdata_i,
  input  logic             push,
  output logic             full,
  input  logic [PIX_W-1:0] pixel_index_i,
  input  logic             last_pixel_i,
  output logic             q_push_o,
  output cmd_t             q_cmd_o,
  input  logic             q_full_i
);

  localparam int unsigned IW = $clog2(CodeSpace);

  typedef enum logic [5:0] {
    F_IDLE   = 6'b000001,
    F_SEARCH = 6'b000010,
    F_HELD   = 6'b000100,
    F_CLR    = 6'b001000,
    F_LHELD  = 6'b010000,
    F_END    = 6'b100000
  } fstate_e;

  fstate_e          state_q, state_d;
  logic [MCS_W-1:0] mcs_q, mcs_d;
  logic [3:0]       width_q, width_d;
  logic [IW-1:0]    count_q, count_d;
  logic [IW-1:0]    held_q, held_d;
  logic             await_q, await_d;
  logic [PIX_W-1:0] pix_q, pix_d;
  logic             last_q, last_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [IW-1:0]    cmp_idx_q, cmp_idx_d;
  logic             cmp_vld_q, cmp_vld_d;

  logic [3:0]       mcs;
  logic [8:0]       clr_code;
  logic [8:0]       end_code;
  logic [SUM_W-1:0] limit;
  logic [IW+PIX_W-1:0] rd_data;
  logic             match;
  logic             ram_we;
  logic [SUM_W-1:0] grown;

  assign mcs        = eff_mcs(mcs_q);
  assign clr_code   = 9'd1 << mcs;
  assign end_code   = clr_code + 9'd1;
  assign limit      = SUM_W'(CodeSpace - 1) - SUM_W'(end_code);
  assign match      = (rd_data[IW+PIX_W-1:PIX_W] == held_q) && (rd_data[PIX_W-1:0] == pix_q);
  assign grown      = SUM_W'(count_q) + SUM_W'(1) + SUM_W'(end_code);
  assign full       = (state_q != F_IDLE);

  lce_ram #(
    .Width (IW + PIX_W),
    .Depth (CodeSpace)
  ) u_dict (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q),
    .wdata_i ({held_q, pix_q}),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d   = state_q;
    mcs_d     = mcs_q;
    width_d   = width_q;
    count_d   = count_q;
    held_d    = held_q;
    await_d   = await_q;
    pix_d     = pix_q;
    last_d    = last_q;
    idx_d     = idx_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = cmp_vld_q;
    ram_we    = 1'b0;
    q_push_o  = 1'b0;
    q_cmd_o   = '{code: MAX_CODE_W'(held_q), width: width_q, fin: 1'b0};

    case (state_q)
      F_IDLE: begin
        if (cfg_we_i && await_q) begin
          mcs_d   = cfg_wdata_i;
          width_d = eff_mcs(cfg_wdata_i) + 4'd1;
        end
        if (push) begin
          pix_d  = pixel_index_i & PIX_W'(clr_code - 9'd1);
          last_d = last_pixel_i;
          if (await_q) begin
            await_d = 1'b0;
            held_d  = IW'(pixel_index_i & PIX_W'(clr_code - 9'd1));
            width_d = mcs + 4'd1;
            count_d = '0;
            state_d = F_CLR;
          end else begin
            idx_d     = '0;
            cmp_vld_d = 1'b0;
            state_d   = F_SEARCH;
          end
        end
      end
      F_SEARCH: begin
        if (cmp_vld_q && match) begin
          held_d  = cmp_idx_q + IW'(end_code) + IW'(1);
          state_d = last_q ? F_LHELD : F_IDLE;
        end else if (idx_q < count_q) begin
          cmp_idx_d = idx_q;
          cmp_vld_d = 1'b1;
          idx_d     = idx_q + IW'(1);
        end else if (cmp_vld_q) begin
          cmp_vld_d = 1'b0;
        end else begin
          ram_we  = 1'b1;
          count_d = count_q + IW'(1);
          if ((grown > (SUM_W'(1) << width_q)) && (width_q < 4'(MAX_CODE_W))) begin
            width_d = width_q + 4'd1;
          end
          state_d = F_HELD;
        end
      end
      F_HELD: begin
        q_push_o = !q_full_i;
        if (!q_full_i) begin
          held_d = IW'(pix_q);
          if (SUM_W'(count_q) >= limit) begin
            state_d = F_CLR;
          end else begin
            state_d = last_q ? F_LHELD : F_IDLE;
          end
        end
      end
      F_CLR: begin
        q_push_o     = !q_full_i;
        q_cmd_o.code = MAX_CODE_W'(clr_code);
        if (!q_full_i) begin
          count_d = '0;
          width_d = mcs + 4'd1;
          state_d = last_q ? F_LHELD : F_IDLE;
        end
      end
      F_LHELD: begin
        q_push_o = !q_full_i;
        if (!q_full_i) begin
          state_d = F_END;
        end
      end
      F_END: begin
        q_push_o     = !q_full_i;
        q_cmd_o.code = MAX_CODE_W'(end_code);
        q_cmd_o.fin  = 1'b1;
        if (!q_full_i) begin
          count_d = '0;
          held_d  = '0;
          width_d = mcs + 4'd1;
          await_d = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      mcs_q     <= MCS_W'(2);
      width_q   <= 4'd3;
      count_q   <= '0;
      held_q    <= '0;
      await_q   <= 1'b1;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mcs_q     <= mcs_d;
      width_q   <= width_d;
      count_q   <= count_d;
      held_q    <= held_d;
      await_q   <= await_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q     <= pix_d;
    last_q    <= last_d;
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
  end

`ifndef SYNTHESIS
  a_count_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_IDLE) |-> (SUM_W'(count_q) < limit))
    else $error("dictionary count reached the limit while idle");
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> !q_full_i)
    else $error("command pushed into a full queue");
`endif

endmodule

// ===== sv/lce_cmdq.sv =====
module lce_cmdq
  import lce_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic vld_o,
  output cmd_t cmd_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned AW    = $clog2(Depth);

  cmd_t         mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign vld_o   = (cnt_q != '0);
  assign cmd_o   = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + AW'(1);
      if (do_pop)  rp_q <= rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= cmd_i;
  end

endmodule

// ===== sv/lce_pack.sv =====
module lce_pack
  import lce_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_vld_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] code_byte_o,
  output logic       last_byte_o
);

  logic [23:0] acc_q;
  logic [4:0]  fill_q;
  logic        fin_q, busy_q, ovld_q;
  logic        adv;
  logic        emit;
  logic [MAX_CODE_W:0] mask;

  assign adv       = !ovld_q || pop;
  assign empty     = !ovld_q;
  assign cmd_pop_o = !busy_q && cmd_vld_i;
  assign mask      = ((MAX_CODE_W+1)'(1) << cmd_i.width) - (MAX_CODE_W+1)'(1);
  assign emit      = busy_q && adv && ((fill_q >= 5'd8) || (fin_q && (fill_q != '0)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      fill_q <= '0;
      fin_q  <= 1'b0;
      busy_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      if (emit) ovld_q <= 1'b1;
      else if (pop) ovld_q <= 1'b0;
      if (!busy_q) begin
        if (cmd_vld_i) begin
          acc_q  <= acc_q | (24'(cmd_i.code & mask[MAX_CODE_W-1:0]) << fill_q);
          fill_q <= fill_q + 5'(cmd_i.width);
          fin_q  <= cmd_i.fin;
          busy_q <= 1'b1;
        end
      end else if (fill_q >= 5'd8) begin
        if (adv) begin
          acc_q  <= acc_q >> 8;
          fill_q <= fill_q - 5'd8;
        end
      end else if (fin_q && (fill_q != '0)) begin
        // pad out the final partial byte
        if (adv) begin
          acc_q  <= '0;
          fill_q <= '0;
        end
      end else begin
        busy_q <= 1'b0;
        fin_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      code_byte_o <= acc_q[7:0];
      last_byte_o <= fin_q && (fill_q <= 5'd8);
    end
  end

`ifndef SYNTHESIS
  a_fill_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (fill_q < 5'd8))
    else $error("packer idle with a whole byte left");
`endif

endmodule

// ===== verif/tb_lzw_code_stream_encoder.sv =====
module tb_lzw_code_stream_encoder;
  import lce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             fin;
  } pixel_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } code_beat_t;

  localparam int unsigned DictSize   = CODE_SPACE_DEF;
  localparam int unsigned CycleLimit = 4000000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [MCS_W-1:0] cfg_wdata_i = '0;
  logic             push = 1'b0;
  logic             full;
  logic [PIX_W-1:0] pixel_index_i = '0;
  logic             last_pixel_i = 1'b0;
  logic             empty;
  logic             pop = 1'b0;
  logic [7:0]       code_byte_o;
  logic             last_byte_o;

  lzw_code_stream_encoder dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .push, .full,
    .pixel_index_i, .last_pixel_i, .empty, .pop, .code_byte_o, .last_byte_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Encoder mirror: dictionary and bit packer state
  logic [10:0] dict_prefix [DictSize];
  logic [7:0]  dict_suffix [DictSize];
  int unsigned n_entries;
  int unsigned cur_prefix;
  int unsigned cur_width;
  int unsigned acc;
  int unsigned acc_bits;
  bit          between_images;
  logic [3:0]  mcs_reg;

  pixel_beat_t pending_pixels[$];
  code_beat_t  expected_bytes[$];
  int unsigned n_errors;
  int unsigned cycle_count;
  bit          stall_hold;

  function automatic int unsigned clamp_mcs(logic [3:0] m);
    if (m < 4'd2) return 2;
    if (m > 4'd8) return 8;
    return m;
  endfunction

  function automatic void pack_code(int unsigned code);
    acc |= (code & ((1 << cur_width) - 1)) << acc_bits;
    acc_bits += cur_width;
    while (acc_bits >= 8) begin
      expected_bytes.push_back({acc[7:0], 1'b0});
      acc >>= 8;
      acc_bits -= 8;
    end
    acc &= 32'hff_ffff;
  endfunction

  function automatic void encode_pixel(pixel_beat_t b);
    int unsigned m, clr, eoi, lim, px, i;
    bit hit;
    m   = clamp_mcs(mcs_reg);
    clr = 1 << m;
    eoi = clr + 1;
    lim = DictSize - 1 - eoi;
    px  = b.pix & (clr - 1);
    if (between_images) begin
      n_entries = 0;
      cur_width = m + 1;
      acc = 0;
      acc_bits = 0;
      pack_code(clr);
      cur_prefix = px;
      between_images = 1'b0;
    end else begin
      hit = 1'b0;
      for (i = 0; i < n_entries; i++) begin
        if (dict_prefix[i] == cur_prefix && dict_suffix[i] == px) begin
          hit = 1'b1;
          break;
        end
      end
      if (hit) begin
        cur_prefix = i + eoi + 1;
      end else begin
        dict_prefix[n_entries] = 11'(cur_prefix);
        dict_suffix[n_entries] = 8'(px);
        n_entries++;
        if (n_entries + eoi > (1 << cur_width) && cur_width < 12) cur_width++;
        pack_code(cur_prefix);
        cur_prefix = px;
        if (n_entries >= lim) begin
          pack_code(clr);
          n_entries = 0;
          cur_width = m + 1;
        end
      end
    end
    if (b.fin) begin
      pack_code(cur_prefix);
      pack_code(eoi);
      if (acc_bits > 0) expected_bytes.push_back({acc[7:0], 1'b0});
      expected_bytes[$].fin = 1'b1;
      acc = 0;
      acc_bits = 0;
      n_entries = 0;
      cur_prefix = 0;
      cur_width = m + 1;
      between_images = 1'b1;
    end
  endfunction

  // Driver
  int unsigned push_gap;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        encode_pixel('{pix: pixel_index_i, fin: last_pixel_i});
        void'(pending_pixels.pop_front());
      end
      if (push && full) begin
        // hold the offered beat
      end else if (push_gap > 0) begin
        push_gap--;
        push <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        pixel_beat_t nx;
        nx = pending_pixels[0];
        push <= 1'b1;
        pixel_index_i <= nx.pix;
        last_pixel_i <= nx.fin;
        if ($urandom_range(0, 3) == 0)
          push_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 3);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte %02h last %0b", $time, code_byte_o, last_byte_o);
          n_errors++;
        end else begin
          code_beat_t e;
          e = expected_bytes.pop_front();
          if (e.data !== code_byte_o) begin
            $display("%0t: code_byte expected %02h actual %02h", $time, e.data,
                     code_byte_o);
            n_errors++;
          end
          if (e.fin !== last_byte_o) begin
            $display("%0t: last_byte expected %0b actual %0b", $time, e.fin,
                     last_byte_o);
            n_errors++;
          end
        end
      end
      if (stall_hold) pop <= 1'b0;
      else if ($urandom_range(0, 15) == 0) pop <= 1'b0;
      else if ($urandom_range(0, 40) == 0) pop <= 1'b0;
      else pop <= 1'b1;
    end
  end

  // Long receiver stall while the long image is still being offered
  initial begin
    stall_hold = 1'b0;
    wait (rst_ni);
    while (pending_pixels.size() < 100) @(posedge clk_i);
    stall_hold = 1'b1;
    repeat (3000) @(posedge clk_i);
    stall_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** lzw_code_stream_encoder: FAILED **");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || push || expected_bytes.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_mcs(logic [3:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (between_images) begin
      mcs_reg = v;
      cur_width = clamp_mcs(mcs_reg) + 1;
    end
  endtask

  task automatic add_pixel(int unsigned p, bit l);
    pending_pixels.push_back('{pix: p[7:0], fin: l});
  endtask

  // Image of random content drawn from values 0 to alpha; a small alpha produces hits
  task automatic add_image(int unsigned len, int unsigned alpha);
    for (int unsigned k = 0; k < len; k++)
      add_pixel($urandom_range(0, alpha), k == len - 1);
  endtask

  initial begin
    logic [3:0] mv;
    n_errors = 0;
    cycle_count = 0;
    n_entries = 0;
    cur_prefix = 0;
    acc = 0;
    acc_bits = 0;
    between_images = 1'b1;
    mcs_reg = 4'd2;
    cur_width = 3;
    push_gap = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single-pixel and short images, extreme and out-of-range pixels and code sizes
    add_pixel(0, 1'b1);
    add_pixel(8'hff, 1'b1);
    add_pixel(1, 1'b0); add_pixel(1, 1'b0); add_pixel(1, 1'b0);
    add_pixel(1, 1'b0); add_pixel(8'hfe, 1'b1);
    wait_drained();
    set_mcs(4'd8);
    add_pixel(8'hff, 1'b0); add_pixel(8'h00, 1'b0); add_pixel(8'hff, 1'b0);
    add_pixel(8'h00, 1'b0); add_pixel(8'haa, 1'b0); add_pixel(8'h55, 1'b1);
    wait_drained();
    set_mcs(4'd0);
    add_pixel(3, 1'b0); add_pixel(2, 1'b0); add_pixel(3, 1'b1);
    wait_drained();
    set_mcs(4'd15);
    add_pixel(8'h80, 1'b1);
    // write during an image is ignored
    add_pixel(7, 1'b0); add_pixel(9, 1'b0);
    wait_drained();
    set_mcs(4'd3);
    add_pixel(7, 1'b1);
    wait_drained();

    // Random images; a long one with a tiny alphabet runs into the long stall
    set_mcs(4'd2);
    add_image(150, 3);
    wait_drained();
    for (int r = 0; r < 8; r++) begin
      mv = $urandom_range(0, 15);
      set_mcs(mv);
      add_image($urandom_range(1, 25), (r % 2) ? 255 : (1 << clamp_mcs(mv)) - 1);
      wait_drained();
    end
    if (n_errors == 0) $display("** lzw_code_stream_encoder: PASSED **");
    else $display("** lzw_code_stream_encoder: FAILED **");
    $finish;
  end

endmodule

// ===== lzw_code_stream_encoder.f =====
sv/lce_pkg.sv
sv/lce_ram.sv
sv/lce_front.sv
sv/lce_cmdq.sv
sv/lce_pack.sv
sv/lzw_code_stream_encoder.sv
verif/tb_lzw_code_stream_encoder.sv
